### hw/rtl/hrt_pkg.sv
// Shared types and character constants for the HTTP request tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package hrt_pkg;

	// Characters the tokenizer looks for
	localparam logic [7:0] CHAR_SPACE     = 8'h20;
	localparam logic [7:0] CHAR_COLON     = 8'h3A;
	localparam logic [7:0] CHAR_SLASH     = 8'h2F;
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
	localparam logic [7:0] CHAR_ZERO      = 8'h30;
	localparam logic [7:0] CHAR_NINE      = CHAR_ZERO + 8'd9;
	localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
	localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;

	// Byte roles reported with each result
	localparam logic [2:0] ROLE_IGNORED = 3'd0;
	localparam logic [2:0] ROLE_METHOD  = 3'd1;
	localparam logic [2:0] ROLE_URL     = 3'd2;
	localparam logic [2:0] ROLE_VERSION = 3'd3;
	localparam logic [2:0] ROLE_KEY     = 3'd4;
	localparam logic [2:0] ROLE_VALUE   = 3'd5;
	localparam logic [2:0] ROLE_BODY    = 3'd6;
	localparam logic [2:0] ROLE_DELIM   = 3'd7;

	// Classification queue between the front and the back
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	// Classes of one request byte, computed by the front end
	typedef struct packed {
		logic is_alpha;
		logic is_url;
		logic is_blank;
		logic is_colon;
		logic is_newline;
	} byte_class_t;

endpackage
`default_nettype wire

### hw/rtl/hrt_if.sv
// Valid/ready channel interfaces for request bytes, tokens and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface hrt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface hrt_token_if;
	logic        valid;
	logic        ready;
	logic [2:0]  byte_role;
	logic        token_start;
	logic [15:0] token_length;
	logic [7:0]  header_count;
	logic        packet_done;
	logic [3:0]  parse_phase;

	modport source (
		output valid, output byte_role, output token_start, output token_length,
		output header_count, output packet_done, output parse_phase, input ready
	);
	modport sink (
		input valid, input byte_role, input token_start, input token_length,
		input header_count, input packet_done, input parse_phase, output ready
	);
endinterface

interface hrt_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] body_length;

	modport source (output valid, output body_length, input ready);
	modport sink (input valid, input body_length, output ready);
endinterface
`default_nettype wire

### hw/rtl/hrt_classify.sv
// Front end: accepts request bytes and sorts each into character classes.
`timescale 1ns / 1ps
`default_nettype none
module hrt_classify (
	hrt_byte_if.sink          bytes,
	output logic              push_valid,
	output hrt_pkg::byte_class_t push_data,
	input  logic              push_ready
);
	import hrt_pkg::*;

	logic is_alpha;
	logic is_digit;

	// Classify the incoming byte
	always_comb begin
		is_alpha = (bytes.data_byte inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) ||
			(bytes.data_byte inside {[CHAR_UPPER_A:CHAR_UPPER_Z]});
		is_digit = bytes.data_byte inside {[CHAR_ZERO:CHAR_NINE]};
		push_data.is_alpha   = is_alpha;
		push_data.is_url     = is_alpha || is_digit ||
			(bytes.data_byte inside {CHAR_SLASH, CHAR_BACKSLASH});
		push_data.is_blank   = bytes.data_byte == CHAR_SPACE;
		push_data.is_colon   = bytes.data_byte == CHAR_COLON;
		push_data.is_newline = bytes.data_byte == CHAR_NEWLINE;
	end

	// Pass the transaction on whenever the queue has room
	assign push_valid  = bytes.valid;
	assign bytes.ready = push_ready;

endmodule
`default_nettype wire

### hw/rtl/hrt_queue.sv
// Short FIFO of classified bytes between the front end and the parser engine.
`timescale 1ns / 1ps
`default_nettype none
module hrt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	input  hrt_pkg::byte_class_t push_data,
	output logic                 push_ready,
	output logic                 pop_valid,
	output hrt_pkg::byte_class_t pop_data,
	input  logic                 pop
);
	import hrt_pkg::*;

	localparam logic [QUEUE_PTR_BITS:0] COUNT_FULL = (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
	localparam logic [QUEUE_PTR_BITS:0] COUNT_ONE  = (QUEUE_PTR_BITS + 1)'(1);
	localparam logic [QUEUE_PTR_BITS-1:0] PTR_ONE  = QUEUE_PTR_BITS'(1);

	byte_class_t                entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0]  wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0]  rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]    count_q;
	logic                       do_push;
	logic                       do_pop;

	assign push_ready = count_q != COUNT_FULL;
	assign pop_valid  = count_q != '0;
	assign pop_data   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_ONE;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_ONE;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + COUNT_ONE;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - COUNT_ONE;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/hrt_engine.sv
// Back end: request state machine, token and header counters, result register.
`timescale 1ns / 1ps
`default_nettype none
module hrt_engine #(
	parameter int LENGTH_BITS       = 16,
	parameter int HEADER_COUNT_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  hrt_pkg::byte_class_t head,
	output logic                 head_pop,
	input  logic [15:0]          body_length,
	hrt_token_if.source          tokens
);
	import hrt_pkg::*;

	localparam int LW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
	localparam int HW = (HEADER_COUNT_BITS > 8) ? HEADER_COUNT_BITS : 8;
	localparam logic [LENGTH_BITS-1:0]       LEN_ONE = LENGTH_BITS'(1);
	localparam logic [HEADER_COUNT_BITS-1:0] HDR_ONE = HEADER_COUNT_BITS'(1);
	localparam logic [LW-1:0] TOKEN_LIMIT  = LW'(16'hFFFF);
	localparam logic [HW-1:0] HEADER_LIMIT = HW'(8'hFF);

	typedef enum logic [9:0] {
		PH_GROUND   = 10'b00_0000_0001,
		PH_METHOD   = 10'b00_0000_0010,
		PH_URL      = 10'b00_0000_0100,
		PH_URL_TEXT = 10'b00_0000_1000,
		PH_VERSION  = 10'b00_0001_0000,
		PH_VER_TEXT = 10'b00_0010_0000,
		PH_KEY      = 10'b00_0100_0000,
		PH_VALUE    = 10'b00_1000_0000,
		PH_HDR_END  = 10'b01_0000_0000,
		PH_BODY     = 10'b10_0000_0000
	} phase_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_OPEN,
		ACT_EXTEND,
		ACT_DELIM
	} act_t;

	phase_t                       phase_q;
	logic [LENGTH_BITS-1:0]       token_count_q;
	logic [HEADER_COUNT_BITS-1:0] headers_q;
	logic [LENGTH_BITS-1:0]       body_count_q;

	phase_t                       phase_n;
	act_t                         act;
	logic [2:0]                   role;
	logic                         done;
	logic [LENGTH_BITS-1:0]       token_n;
	logic [HEADER_COUNT_BITS-1:0] headers_n;
	logic [LENGTH_BITS-1:0]       body_n;
	logic [LW-1:0]                token_wide;
	logic [HW-1:0]                headers_wide;
	logic [3:0]                   phase_num;
	logic                         step;

	logic                         out_valid_q;
	logic [2:0]                   role_q;
	logic                         start_q;
	logic [15:0]                  token_length_q;
	logic [7:0]                   header_count_q;
	logic                         done_q;
	logic [3:0]                   phase_num_q;

	// Take the queue head when the result register is free or being drained
	assign step     = head_valid && (!out_valid_q || tokens.ready);
	assign head_pop = step;

	// Next state, role and counter action for the head byte
	always_comb begin
		phase_n   = phase_q;
		act       = ACT_NONE;
		role      = ROLE_IGNORED;
		done      = 1'b0;
		headers_n = headers_q;
		body_n    = body_count_q;
		case (phase_q)
			PH_GROUND: begin
				if (head.is_alpha) begin
					role    = ROLE_METHOD;
					act     = ACT_OPEN;
					phase_n = PH_METHOD;
				end
			end
			PH_METHOD: begin
				if (head.is_blank) begin
					act     = ACT_DELIM;
					phase_n = PH_URL;
				end else begin
					role = ROLE_METHOD;
					act  = ACT_EXTEND;
				end
			end
			PH_URL: begin
				if (head.is_url) begin
					role    = ROLE_URL;
					act     = ACT_OPEN;
					phase_n = PH_URL_TEXT;
				end
			end
			PH_URL_TEXT: begin
				if (head.is_blank) begin
					act     = ACT_DELIM;
					phase_n = PH_VERSION;
				end else if (head.is_url) begin
					role = ROLE_URL;
					act  = ACT_EXTEND;
				end
			end
			PH_VERSION: begin
				if (!head.is_blank) begin
					role    = ROLE_VERSION;
					act     = ACT_OPEN;
					phase_n = PH_VER_TEXT;
				end
			end
			PH_VER_TEXT: begin
				if (head.is_newline) begin
					act     = ACT_DELIM;
					phase_n = PH_KEY;
				end else if (!head.is_blank) begin
					role = ROLE_VERSION;
					act  = ACT_EXTEND;
				end
			end
			PH_KEY: begin
				if (head.is_alpha) begin
					role = ROLE_KEY;
					act  = (token_count_q == '0) ? ACT_OPEN : ACT_EXTEND;
				end else if (head.is_colon) begin
					act     = ACT_DELIM;
					phase_n = PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (head.is_alpha) begin
					role = ROLE_VALUE;
					act  = (token_count_q == '0) ? ACT_OPEN : ACT_EXTEND;
				end else if (head.is_newline) begin
					act       = ACT_DELIM;
					headers_n = (headers_q == '1) ? headers_q : headers_q + HDR_ONE;
					phase_n   = PH_HDR_END;
				end
			end
			PH_HDR_END: begin
				if (head.is_newline) begin
					act     = ACT_DELIM;
					phase_n = PH_BODY;
					body_n  = '0;
					done    = body_length == 16'h0000;
				end else if (head.is_alpha) begin
					role    = ROLE_KEY;
					act     = ACT_OPEN;
					phase_n = PH_KEY;
				end
			end
			PH_BODY: begin
				role   = ROLE_BODY;
				act    = (body_count_q == '0) ? ACT_OPEN : ACT_EXTEND;
				body_n = (body_count_q == '1) ? body_count_q : body_count_q + LEN_ONE;
				done   = LW'(body_n) >= LW'(body_length);
			end
			default: begin
				phase_n = PH_GROUND;
			end
		endcase

		// Apply the counter action
		case (act)
			ACT_OPEN:   token_n = LEN_ONE;
			ACT_EXTEND: token_n = (token_count_q == '1) ? token_count_q :
				token_count_q + LEN_ONE;
			ACT_DELIM:  token_n = '0;
			default:    token_n = token_count_q;
		endcase

		// Drop back to ground at request end
		if (done) begin
			phase_n = PH_GROUND;
		end
	end

	// Widen reported counts for clamping and encode the phase number
	always_comb begin
		token_wide   = LW'(token_n);
		headers_wide = HW'(headers_n);
		phase_num    = '0;
		for (int i = 0; i < 10; i++) begin
			if (phase_n[i]) begin
				phase_num = 4'(i);
			end
		end
	end

	// Update parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_GROUND;
			token_count_q <= '0;
			headers_q     <= '0;
			body_count_q  <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			if (done) begin
				token_count_q <= '0;
				headers_q     <= '0;
				body_count_q  <= '0;
			end else begin
				token_count_q <= token_n;
				headers_q     <= headers_n;
				body_count_q  <= body_n;
			end
		end
	end

	// Hold the result until the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (tokens.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			role_q         <= role;
			start_q        <= act == ACT_OPEN;
			token_length_q <= (token_wide > TOKEN_LIMIT) ? 16'hFFFF : token_wide[15:0];
			header_count_q <= (headers_wide > HEADER_LIMIT) ? 8'hFF : headers_wide[7:0];
			done_q         <= done;
			phase_num_q    <= phase_num;
		end
	end

	assign tokens.valid        = out_valid_q;
	assign tokens.byte_role    = role_q;
	assign tokens.token_start  = start_q;
	assign tokens.token_length = token_length_q;
	assign tokens.header_count = header_count_q;
	assign tokens.packet_done  = done_q;
	assign tokens.parse_phase  = phase_num_q;

endmodule
`default_nettype wire

### hw/rtl/http_request_header_tokenizer_core.sv
// Top level of the HTTP request tokenizer: front end, queue, engine, config.
//
//   Channel  Direction  Payload                                   Accepted when
//   bytes    sink       data_byte[7:0]                            valid && ready
//   tokens   source     byte_role, token_start, token_length,     valid && ready
//                       header_count, packet_done, parse_phase
//   cfg      sink       body_length[15:0]                         valid && ready
//
// One byte per cycle sustained while tokens.ready stays high; each byte is
// registered in the queue, then the engine loads the result register from
// the queue head. The engine's state update sets the rate.
// Reset clears the parser state, the queue and body_length to zero.
// A stalled result stops the engine; the four-entry queue keeps taking bytes
// until it fills, then bytes.ready drops. cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none
module http_request_header_tokenizer_core #(
	parameter int LENGTH_BITS       = 16,
	parameter int HEADER_COUNT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	hrt_byte_if.sink    bytes,
	hrt_token_if.source tokens,
	hrt_cfg_if.sink     cfg
);
	import hrt_pkg::*;

	logic        push_valid;
	logic        push_ready;
	byte_class_t push_data;
	logic        pop_valid;
	logic        pop;
	byte_class_t pop_data;
	logic [15:0] body_length_q;

	// Capture body length writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_length_q <= '0;
		end else if (cfg.valid) begin
			body_length_q <= cfg.body_length;
		end
	end

	hrt_classify u_classify (
		.bytes      (bytes),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	hrt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop        (pop)
	);

	hrt_engine #(
		.LENGTH_BITS       (LENGTH_BITS),
		.HEADER_COUNT_BITS (HEADER_COUNT_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (pop_valid),
		.head        (pop_data),
		.head_pop    (pop),
		.body_length (body_length_q),
		.tokens      (tokens)
	);

endmodule
`default_nettype wire

### tb/tb_http_request_header_tokenizer_core.sv
// Self-checking testbench for the HTTP request tokenizer core.
`timescale 1ns / 1ps
module tb_http_request_header_tokenizer_core;
	import hrt_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_BYTES = 400;

	// Parser states, numbered as the block reports them
	typedef enum logic [3:0] {
		PH_GROUND, PH_METHOD, PH_URL, PH_URL_TEXT, PH_VERSION,
		PH_VERSION_TEXT, PH_KEY, PH_VALUE, PH_HEADER_END, PH_BODY
	} parse_phase_t;

	// What a byte does to the current token
	typedef enum logic [1:0] {TOK_KEEP, TOK_OPEN, TOK_EXTEND, TOK_CLEAR} token_action_t;

	typedef struct packed {
		logic [2:0]  byte_role;
		logic        token_start;
		logic [15:0] token_length;
		logic [7:0]  header_count;
		logic        packet_done;
		logic [3:0]  parse_phase;
	} token_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hrt_byte_if  byte_ch();
	hrt_token_if tok_ch();
	hrt_cfg_if   cfg_ch();

	http_request_header_tokenizer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.tokens (tok_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Tokenizer state as predicted
	parse_phase_t  st_phase = PH_GROUND;
	logic [15:0]   st_token_len = '0;
	logic [7:0]    st_headers = '0;
	logic [15:0]   st_body_count = '0;
	logic [15:0]   cfg_body_length = '0;

	token_result_t expected_tokens[$];
	int            mismatches = 0;
	int            results_seen = 0;
	int            bytes_sent = 0;
	int            idle_cycles = 0;
	int            cut_left = -1;
	bit            src_idle = 1'b0;
	bit            sink_idle = 1'b0;
	int            hold_req = 0;
	int            hold_left = 0;
	int            stall_left = 0;

	function automatic bit alpha_char(input logic [7:0] c);
		return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
			(c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z);
	endfunction

	function automatic bit is_url_char(input logic [7:0] c);
		return alpha_char(c) || (c >= CHAR_ZERO && c <= CHAR_NINE) ||
			c == CHAR_SLASH || c == CHAR_BACKSLASH;
	endfunction

	// Advance the tokenizer by one byte and return the result it reports
	function automatic token_result_t predict_token(input logic [7:0] c);
		token_result_t r;
		token_action_t act;
		logic          done;
		r = '0;
		r.byte_role = ROLE_IGNORED;
		act = TOK_KEEP;
		done = 1'b0;
		case (st_phase)
			PH_GROUND: if (alpha_char(c)) begin
				r.byte_role = ROLE_METHOD;
				act = TOK_OPEN;
				st_phase = PH_METHOD;
			end
			PH_METHOD: if (c == CHAR_SPACE) begin
				act = TOK_CLEAR;
				st_phase = PH_URL;
			end else begin
				r.byte_role = ROLE_METHOD;
				act = TOK_EXTEND;
			end
			PH_URL: if (is_url_char(c)) begin
				r.byte_role = ROLE_URL;
				act = TOK_OPEN;
				st_phase = PH_URL_TEXT;
			end
			PH_URL_TEXT: if (c == CHAR_SPACE) begin
				act = TOK_CLEAR;
				st_phase = PH_VERSION;
			end else if (is_url_char(c)) begin
				r.byte_role = ROLE_URL;
				act = TOK_EXTEND;
			end
			PH_VERSION: if (c != CHAR_SPACE) begin
				r.byte_role = ROLE_VERSION;
				act = TOK_OPEN;
				st_phase = PH_VERSION_TEXT;
			end
			PH_VERSION_TEXT: if (c == CHAR_NEWLINE) begin
				act = TOK_CLEAR;
				st_phase = PH_KEY;
			end else if (c != CHAR_SPACE) begin
				r.byte_role = ROLE_VERSION;
				act = TOK_EXTEND;
			end
			PH_KEY: if (alpha_char(c)) begin
				r.byte_role = ROLE_KEY;
				act = (st_token_len == 0) ? TOK_OPEN : TOK_EXTEND;
			end else if (c == CHAR_COLON) begin
				act = TOK_CLEAR;
				st_phase = PH_VALUE;
			end
			PH_VALUE: if (alpha_char(c)) begin
				r.byte_role = ROLE_VALUE;
				act = (st_token_len == 0) ? TOK_OPEN : TOK_EXTEND;
			end else if (c == CHAR_NEWLINE) begin
				act = TOK_CLEAR;
				if (st_headers != '1)
					st_headers++;
				st_phase = PH_HEADER_END;
			end
			PH_HEADER_END: if (c == CHAR_NEWLINE) begin
				act = TOK_CLEAR;
				st_phase = PH_BODY;
				st_body_count = '0;
				if (cfg_body_length == 0)
					done = 1'b1;
			end else if (alpha_char(c)) begin
				r.byte_role = ROLE_KEY;
				act = TOK_OPEN;
				st_phase = PH_KEY;
			end
			PH_BODY: begin
				r.byte_role = ROLE_BODY;
				act = (st_body_count == 0) ? TOK_OPEN : TOK_EXTEND;
				if (st_body_count != '1)
					st_body_count++;
				if (st_body_count >= cfg_body_length)
					done = 1'b1;
			end
			default: st_phase = PH_GROUND;
		endcase

		case (act)
			TOK_OPEN: begin
				r.token_start = 1'b1;
				st_token_len = 16'd1;
			end
			TOK_EXTEND: if (st_token_len != '1)
				st_token_len++;
			TOK_CLEAR: st_token_len = '0;
			default: ;
		endcase

		r.token_length = st_token_len;
		r.header_count = st_headers;
		r.packet_done = done;
		// Request end: clear everything, but the result keeps the old header count
		if (done) begin
			st_phase = PH_GROUND;
			st_token_len = '0;
			st_headers = '0;
			st_body_count = '0;
		end
		r.parse_phase = st_phase;
		return r;
	endfunction

	function automatic int pick_gap(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(1))
			return CHAR_UPPER_A + 8'($urandom_range(25));
		return CHAR_LOWER_A + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] rand_url_char();
		logic [7:0] x;
		do x = 8'($urandom); while (!is_url_char(x));
		return x;
	endfunction

	// Byte that is neither a URL character nor a space
	function automatic logic [7:0] rand_non_url();
		logic [7:0] x;
		do x = 8'($urandom); while (is_url_char(x) || x == CHAR_SPACE);
		return x;
	endfunction

	// Non-letter byte other than the given stop character
	function automatic logic [7:0] rand_noise(input logic [7:0] stop);
		logic [7:0] x;
		do x = 8'($urandom); while (alpha_char(x) || x == stop);
		return x;
	endfunction

	function automatic logic [7:0] rand_byte_except(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		do x = 8'($urandom); while (x == a || x == b);
		return x;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 40)
			$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				results_seen, name, got, want));
	endtask

	// Offer one byte, hold it until the transaction completes, then predict
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap(src_idle);
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		expected_tokens.push_back(predict_token(b));
		bytes_sent++;
	endtask

	// Send unless a broken request has been cut off
	task automatic put_byte(input logic [7:0] b);
		if (cut_left != 0) begin
			send_byte(b);
			if (cut_left > 0)
				cut_left--;
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic wait_for_results();
		byte_ch.valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write body_length once the block has gone idle
	task automatic write_body_length(input logic [15:0] value);
		wait_for_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.body_length <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_body_length = value;
		cfg_ch.valid <= 1'b0;
	endtask

	// Well-formed request with random content; a broken one is cut short
	// and followed by a burst of random bytes
	task automatic send_random_request(input bit broken);
		int n_hdr;
		cut_left = broken ? int'($urandom_range(1, 30)) : -1;
		repeat ($urandom_range(0, 2)) put_byte(rand_noise(CHAR_SPACE));
		put_byte(rand_letter());
		repeat ($urandom_range(0, 5)) put_byte(rand_byte_except(CHAR_SPACE, CHAR_SPACE));
		put_byte(CHAR_SPACE);
		repeat ($urandom_range(0, 1))
			put_byte($urandom_range(1) ? CHAR_SPACE : rand_non_url());
		put_byte(rand_url_char());
		repeat ($urandom_range(0, 6))
			put_byte(($urandom_range(4) == 0) ? rand_non_url() : rand_url_char());
		put_byte(CHAR_SPACE);
		repeat ($urandom_range(0, 1)) put_byte(CHAR_SPACE);
		put_byte(rand_byte_except(CHAR_SPACE, CHAR_SPACE));
		repeat ($urandom_range(0, 6))
			put_byte(($urandom_range(5) == 0) ? CHAR_SPACE :
				rand_byte_except(CHAR_SPACE, CHAR_NEWLINE));
		put_byte(CHAR_NEWLINE);
		n_hdr = $urandom_range(1, 4);
		for (int h = 0; h < n_hdr; h++) begin
			// later keys are opened from the header-end state
			if (h != 0)
				put_byte(rand_letter());
			repeat ($urandom_range(0, 4))
				put_byte(($urandom_range(4) == 0) ? rand_noise(CHAR_COLON) : rand_letter());
			put_byte(CHAR_COLON);
			repeat ($urandom_range(0, 5))
				put_byte(($urandom_range(4) == 0) ? rand_noise(CHAR_NEWLINE) : rand_letter());
			put_byte(CHAR_NEWLINE);
			if ($urandom_range(7) == 0)
				put_byte(rand_noise(CHAR_NEWLINE));
		end
		put_byte(CHAR_NEWLINE);
		repeat (cfg_body_length) put_byte(8'($urandom));
		if (broken)
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
		cut_left = -1;
	endtask

	// Roles up to value, some ignored bytes, empty value, zero body length
	task automatic test_short_request();
		src_idle = 1'b1;
		sink_idle = 1'b1;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("GE  ~/a! V 1\nk-:v\nQ:\n\n");
	endtask

	// Body bytes until the configured length ends the request
	task automatic test_body_end();
		write_body_length(16'd3);
		send_text("P /9\\ V\nk:v\n\nxyz");
	endtask

	// Lower body_length below the bytes already counted, mid-body
	task automatic test_body_length_lowered();
		write_body_length(16'h5A5A);
		send_text("G / V\nk:v\n\nabcde");
		write_body_length(16'd2);
		send_byte(8'hC3);
	endtask

	// Hold off the result side long enough for the input to back up
	task automatic test_output_stall();
		write_body_length(16'd4);
		src_idle = 1'b0;
		sink_idle = 1'b0;
		hold_req = 120;
		repeat (3) send_random_request(1'b0);
	endtask

	task automatic test_random_traffic();
		int stop_at;
		stop_at = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(3) == 0)
				write_body_length(($urandom_range(9) == 0) ?
					16'($urandom_range(9, 40)) : 16'($urandom_range(0, 8)));
			src_idle = ($urandom_range(3) != 0);
			sink_idle = ($urandom_range(3) != 0);
			if ($urandom_range(9) == 0)
				repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
			else
				send_random_request($urandom_range(5) == 0);
		end
	endtask

	// Drive the result ready: forced holds, random stalls, otherwise ready
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			tok_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			tok_ch.ready <= 1'b0;
		end else if (sink_idle && $urandom_range(99) < 30) begin
			stall_left = pick_gap(1'b1);
			tok_ch.ready <= 1'b0;
		end else begin
			tok_ch.ready <= 1'b1;
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		token_result_t want;
		if (arst_n && tok_ch.valid && tok_ch.ready) begin
			if (expected_tokens.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none expected",
					results_seen));
			end else begin
				want = expected_tokens.pop_front();
				check_field("byte_role", 32'(tok_ch.byte_role), 32'(want.byte_role));
				check_field("token_start", 32'(tok_ch.token_start),
					32'(want.token_start));
				check_field("token_length", 32'(tok_ch.token_length),
					32'(want.token_length));
				check_field("header_count", 32'(tok_ch.header_count),
					32'(want.header_count));
				check_field("packet_done", 32'(tok_ch.packet_done),
					32'(want.packet_done));
				check_field("parse_phase", 32'(tok_ch.parse_phase),
					32'(want.parse_phase));
			end
			results_seen++;
		end
	end

	// Abort when no transaction completes on any channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= 8'h00;
		cfg_ch.valid <= 1'b0;
		cfg_ch.body_length <= 16'h0000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_short_request();
		test_body_end();
		test_body_length_lowered();
		test_output_stall();
		test_random_traffic();
		wait_for_results();

		if (mismatches == 0 && expected_tokens.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### http_request_header_tokenizer_core.f
hw/rtl/hrt_pkg.sv
hw/rtl/hrt_if.sv
hw/rtl/hrt_classify.sv
hw/rtl/hrt_queue.sv
hw/rtl/hrt_engine.sv
hw/rtl/http_request_header_tokenizer_core.sv
tb/tb_http_request_header_tokenizer_core.sv
